// ===== src/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg: shared types, widths and exponent tables for the softmax block
// Holds the field widths, sequencer states and the two exp() lookup tables,
// which are built at elaboration by a fixed-point series.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int MAX_CLASSES = 64;
    localparam int ADDR_W      = $clog2(MAX_CLASSES);
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);

    localparam int LOGIT_W = 16;
    localparam int PROB_W  = 16;
    localparam int CLASS_W = 6;
    localparam int EXP_W   = 28;
    localparam int HI_W    = 28;
    localparam int LO_W    = 17;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = HI_W + LO_W;
    localparam int SUM_W   = EXP_W + ADDR_W;
    localparam int NUM_W   = EXP_W + FRAC_W + 1;
    localparam int QUO_W   = FRAC_W + 1;
    localparam int ROM_N   = 256;

    localparam logic [PROB_W-1:0] PROB_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_STORE,
        S_RD,
        S_DIV_START,
        S_DIV,
        S_OUT
    } t_state;

    typedef logic [ROM_N-1:0][HI_W-1:0] t_hi_rom;
    typedef logic [ROM_N-1:0][LO_W-1:0] t_lo_rom;

    // exp(t), t in Q16 within [0,1], result Q24 (Taylor series, Q30 terms)
    function automatic logic [63:0] series_q24(input logic [63:0] t);
        logic [63:0] term;
        logic [63:0] acc;
        term = 64'd1 << 30;
        acc  = term;
        for (int n = 1; n <= 16; n++) begin
            term = ((term * t) >> 16) / 64'(n);
            acc  = acc + term;
        end
        return (acc + 64'd32) >> 6;
    endfunction

    function automatic logic [63:0] mul_q24(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 23)) >> 24;
    endfunction

    // e and 1/e in Q24
    localparam logic [63:0] E_Q24    = series_q24(64'd65536);
    localparam logic [63:0] EINV_Q24 = ((64'd1 << 48) + (E_Q24 >> 1)) / E_Q24;

    // high byte h (signed): exp(h/16) in Q12.16
    function automatic t_hi_rom build_hi_rom();
        t_hi_rom     rom;
        logic [63:0] base;
        logic [63:0] p;
        logic [63:0] v;
        int          s;
        int          r;
        int          q;
        int          steps;
        for (int idx = 0; idx < ROM_N; idx++) begin
            s     = (idx >= 128) ? idx - 256 : idx;
            r     = idx & 15;
            q     = (s - r) >>> 4;
            base  = (q >= 0) ? E_Q24 : EINV_Q24;
            steps = (q >= 0) ? q : -q;
            p     = 64'd1 << 24;
            for (int k = 0; k < 8; k++) begin
                if (k < steps) begin
                    p = mul_q24(p, base);
                end
            end
            v        = mul_q24(p, series_q24(64'(r) * 64'd4096));
            rom[idx] = HI_W'((v + 64'd128) >> 8);
        end
        return rom;
    endfunction

    // low byte l (unsigned): exp(l/4096) in Q1.16
    function automatic t_lo_rom build_lo_rom();
        t_lo_rom rom;
        for (int idx = 0; idx < ROM_N; idx++) begin
            rom[idx] = LO_W'((series_q24(64'(idx) * 64'd16) + 64'd128) >> 8);
        end
        return rom;
    endfunction

    localparam t_hi_rom HI_ROM = build_hi_rom();
    localparam t_lo_rom LO_ROM = build_lo_rom();

endpackage

// ===== src/smx_ram.sv =====
// ----------------------------------------------------------------------------
// smx_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/smx_exp.sv =====
// ----------------------------------------------------------------------------
// smx_exp: fixed-point exponential
// Two table lookups and one registered product, then round and saturate
// to Q12.16.
// ----------------------------------------------------------------------------
module smx_exp import smx_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [LOGIT_W-1:0] i_logit,
    output logic [EXP_W-1:0]          o_exp
);

    logic [HI_W-1:0]   hi_val;
    logic [LO_W-1:0]   lo_val;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W:0]   rounded;
    logic [PROD_W-FRAC_W:0] shifted;

    assign hi_val = HI_ROM[i_logit[15:8]];
    assign lo_val = LO_ROM[i_logit[7:0]];

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(hi_val) * PROD_W'(lo_val);
    end

    assign rounded = {1'b0, r_prod} + (PROD_W+1)'(1 << (FRAC_W - 1));
    assign shifted = rounded[PROD_W:FRAC_W];
    // clamp to 28 bits
    assign o_exp   = (shifted > (PROD_W-FRAC_W+1)'({EXP_W{1'b1}})) ? '1 : shifted[EXP_W-1:0];

endmodule

// ===== src/smx_div.sv =====
// ----------------------------------------------------------------------------
// smx_div: iterative restoring divider
// One quotient bit per cycle; the top numerator bits are known to be below
// the divisor, so only the low QUO_W quotient bits are produced.
// ----------------------------------------------------------------------------
module smx_div import smx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [SUM_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quotient
);

    localparam int STEP_W = $clog2(QUO_W);

    logic [SUM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_low;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [SUM_W:0]    trial;
    logic              ge;

    assign trial = {r_rem, r_low[QUO_W-1]};
    assign ge    = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SUM_W'(i_num[NUM_W-1:QUO_W]);
            r_low <= i_num[QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? SUM_W'(trial - {1'b0, i_den}) : SUM_W'(trial);
            r_low <= {r_low[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/softmax_normalizer.sv =====
// ----------------------------------------------------------------------------
// softmax_normalizer: softmax over one image's class scores
// Logits (signed Q4.12) arrive one per transfer on the input channel, the
// last of an image flagged by i_last_logit. Each becomes exp() in Q12.16,
// is stored in a 64-entry RAM and added to a running sum. After the last
// logit every stored value is divided by the sum and sent, in arrival
// order, as a Q0.16 probability (saturated at 65535) with its class index
// and a last flag on the final one of the image.
// Input: i_valid / o_stall. A logit is accepted, then passes the table
// product and the store; a logit beyond 64 in one image is dropped.
// Output: o_valid / i_stall. Each probability passes RAM read, divider
// load, the QUO_W quotient bits and a finish step in the shared restoring
// divider, and output; the next read waits until the probability is taken.
// o_stall stays high from an accepted logit until its work is done and,
// after the last logit, until the final probability of the image is taken.
// A stalled output holds its payload; the block simply waits.
// Reset (synchronous, active low) clears the sum, count and sequencer; the
// RAM needs no clearing since only entries written in the image are read.
// ----------------------------------------------------------------------------
module softmax_normalizer import smx_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // logit channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [LOGIT_W-1:0] i_logit,
    input  logic                      i_last_logit,
    // probability channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [PROB_W-1:0]         o_probability,
    output logic [CLASS_W-1:0]        o_class_index,
    output logic                      o_last_probability
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;

    logic signed [LOGIT_W-1:0] r_logit;
    logic                      r_last;
    logic [PROB_W-1:0]         r_prob;

    logic              load_in;
    logic              load_prob;
    logic              wr_en;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  quotient;
    logic [EXP_W-1:0]  exp_val;
    logic [EXP_W-1:0]  rd_data;
    logic [NUM_W-1:0]  numerator;
    logic              final_item;
    logic [PROB_W-1:0] prob_val;

    // exp unit: tables and product, fed from the held logit
    smx_exp u_exp (
        .i_clk   (i_clk),
        .i_logit (r_logit),
        .o_exp   (exp_val)
    );

    smx_ram #(
        .WIDTH (EXP_W),
        .DEPTH (MAX_CLASSES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (exp_val),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    // exp * 2^16 + sum/2 rounds the quotient to nearest
    assign numerator = NUM_W'({rd_data, {FRAC_W{1'b0}}}) + NUM_W'(r_sum >> 1);

    smx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_num      (numerator),
        .i_den      (r_sum),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign final_item = (CNT_W'(r_rd_idx) + 1'b1) == r_count;

    // saturate; an empty sum gives zero
    always_comb begin
        if (r_sum == '0) begin
            prob_val = '0;
        end else if (quotient[QUO_W-1]) begin
            prob_val = PROB_MAX;
        end else begin
            prob_val = quotient[PROB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sum    <= '0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_logit <= i_logit;
            r_last  <= i_last_logit;
        end
        if (load_prob) begin
            r_prob <= prob_val;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sum     = r_sum;
        n_rd_idx  = r_rd_idx;
        load_in   = 1'b0;
        load_prob = 1'b0;
        wr_en     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    load_in = 1'b1;
                    if (r_count < CNT_W'(MAX_CLASSES)) begin
                        n_state = S_MUL;
                    end else if (i_last_logit) begin
                        // store full: drop the logit but still close the image
                        n_rd_idx = '0;
                        n_state  = S_RD;
                    end
                end
            end
            S_MUL: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                wr_en   = 1'b1;
                n_sum   = r_sum + SUM_W'(exp_val);
                n_count = r_count + 1'b1;
                if (r_last) begin
                    n_rd_idx = '0;
                    n_state  = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_DIV_START;
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    load_prob = 1'b1;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (final_item) begin
                        n_count = '0;
                        n_sum   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_state  = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = (r_state == S_OUT);
    assign o_probability      = r_prob;
    assign o_class_index      = CLASS_W'(r_rd_idx);
    assign o_last_probability = final_item;

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CLASSES))
        else $error("stored count exceeds store depth");

    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("probability read beyond stored entries");

    a_image_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_probability) |=> (r_count == '0 && r_sum == '0))
        else $error("state not cleared after final probability");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_last_logit && r_count == CNT_W'(MAX_CLASSES))
        |=> (r_count == CNT_W'(MAX_CLASSES) && $stable(r_sum)))
        else $error("logit stored into a full store");

endmodule
